@@ hdl/hsvg_pkg.sv @@
// Shared constants and types for the HSV gradient pixel converter.
package hsvg_pkg;

    localparam int SIDE_DEFAULT   = 256;
    localparam int DEG_PER_SECTOR = 60;
    localparam int DEG_FULL_TURN  = 360;
    localparam int FULL_SCALE     = 255;

    // Lanes of the shared divide datapath.
    localparam int LANE_V   = 0;
    localparam int LANE_P   = 1;
    localparam int LANE_Q   = 2;
    localparam int LANE_T   = 3;
    localparam int NUM_LANE = 4;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYAN = 3'd2,
        SEC_CYAN_BLU = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } sector_t;

endpackage

@@ hdl/hsv_gradient_pixel_to_rgb.sv @@
// HSV saturation/value picker pixel to RGB converter, seven-stage pipeline.
//
// Give it a pixel (column, row) of a SIDE x SIDE saturation/value square and it
// returns the truncated RGB color for the hue held in hue_degrees. One item is
// taken in every clock cycle: start is sampled each cycle and busy stays low,
// because the receiver cannot stall and nothing inside ever holds. Each result
// comes out marked by a one-cycle done strobe, in input order. The seven stages
// are: clamp and hue decode, channel multiplicands, numerator build, reciprocal
// estimate, estimate back-multiply, remainder correction, and channel routing.
// Every channel is an exact floor division by the constant 60*SIDE^2, done as a
// multiply by a reciprocal that may come out one short, then fixed up by a single
// remainder compare. Coordinates at or past SIDE saturate to SIDE-1; a hue of
// 360 or above wraps by 360. Write hue_degrees only while no item is in flight.
module hsv_gradient_pixel_to_rgb
    import hsvg_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] column,
    input  logic [7:0] row,
    input  logic       hue_degrees_we,
    input  logic [8:0] hue_degrees,
    output logic       done,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    // Largest coordinate after saturation.
    localparam int     LIM    = (SIDE - 1 > 255) ? 255 : SIDE - 1;
    // Multiplicand range: 0 .. 60*SIDE.
    localparam longint FULLM  = longint'(DEG_PER_SECTOR) * longint'(SIDE);
    localparam int     MW     = $clog2(FULLM + 1);
    // Numerator range: row * M * 255.
    localparam longint XMAX   = longint'(FULL_SCALE) * longint'(LIM) * FULLM;
    localparam int     XW     = $clog2(XMAX + 1);
    // Common denominator 60*SIDE^2.
    localparam longint DEN    = FULLM * longint'(SIDE);
    localparam int     DW     = $clog2(DEN + 1);
    // Reciprocal scaled so that X < 2^SH; estimate is short by at most one.
    localparam int     SH     = XW;
    localparam longint RECIP  = (longint'(1) << SH) / DEN;
    localparam int     RW     = $clog2(RECIP + 1);
    localparam int     PW     = (XW + RW > SH + 8) ? XW + RW : SH + 8;

    localparam logic [7:0]    LIM_C   = 8'(LIM);
    localparam logic [MW-1:0] SIDE_C  = MW'(SIDE);
    localparam logic [MW-1:0] FULLM_C = MW'(FULLM);
    localparam logic [MW-1:0] DEG_M   = MW'(DEG_PER_SECTOR);
    localparam logic [5:0]    DEG_C   = 6'(DEG_PER_SECTOR);
    localparam logic [8:0]    TURN_C  = 9'(DEG_FULL_TURN);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [DW-1:0] DEN_C   = DW'(DEN);
    localparam logic [XW-1:0] DEN_X   = XW'(DEN);

    // Configuration register.
    logic [8:0] hue_reg;

    // Valid bits, one per stage.
    logic [7:1] vld_reg;

    // Stage 1 payload.
    logic [7:0] col_s1_reg, row_s1_reg;
    logic [5:0] rem_s1_reg;
    sector_t    sec_s1_reg;

    // Stage 2..6 payload.
    logic [7:0]    row_s2_reg;
    logic [MW-1:0] m_s2_reg [NUM_LANE];
    logic [XW-1:0] x_s3_reg [NUM_LANE];
    logic [XW-1:0] x_s4_reg [NUM_LANE];
    logic [7:0]    est_s4_reg [NUM_LANE];
    logic [XW-1:0] x_s5_reg [NUM_LANE];
    logic [XW-1:0] ed_s5_reg [NUM_LANE];
    logic [7:0]    est_s5_reg [NUM_LANE];
    logic [7:0]    q_s6_reg [NUM_LANE];
    sector_t       sec_s2_reg, sec_s3_reg, sec_s4_reg, sec_s5_reg, sec_s6_reg;

    // Output registers.
    logic [7:0] red_reg, green_reg, blue_reg;

    // Stage 1 next values.
    logic [8:0] hue_wrap;
    logic [7:0] col_next, row_next;
    logic [5:0] rem_next;
    sector_t    sec_next;

    // Stage 2 next values.
    logic [13:0]   cr_q, cr_t;
    logic [5:0]    rem_inv;
    logic [MW-1:0] m_next [NUM_LANE];

    // Stage 3..7 next values.
    logic [MW+15:0] y_ext  [NUM_LANE];
    logic [XW-1:0]  x_next [NUM_LANE];
    logic [PW-1:0]  prod   [NUM_LANE];
    logic [DW+7:0]  ed     [NUM_LANE];
    logic [XW-1:0]  rem_x  [NUM_LANE];
    logic [7:0]     q_next [NUM_LANE];
    logic [7:0]     red_next, green_next, blue_next;

    // Never hold off the source; the pipeline has no stall path.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (hue_degrees_we)
            begin
                hue_reg <= hue_degrees;
            end
            vld_reg <= {vld_reg[6:1], start};
        end
    end

    // Stage 1: saturate coordinates, split hue into sector and remainder.
    always_comb
    begin
        hue_wrap = (hue_reg >= TURN_C) ? hue_reg - TURN_C : hue_reg;
        col_next = (column > LIM_C) ? LIM_C : column;
        row_next = (row > LIM_C) ? LIM_C : row;
        if (hue_wrap < 9'(DEG_PER_SECTOR))
        begin
            sec_next = SEC_RED_YEL;
            rem_next = 6'(hue_wrap);
        end
        else if (hue_wrap < 9'(2 * DEG_PER_SECTOR))
        begin
            sec_next = SEC_YEL_GRN;
            rem_next = 6'(hue_wrap - 9'(DEG_PER_SECTOR));
        end
        else if (hue_wrap < 9'(3 * DEG_PER_SECTOR))
        begin
            sec_next = SEC_GRN_CYAN;
            rem_next = 6'(hue_wrap - 9'(2 * DEG_PER_SECTOR));
        end
        else if (hue_wrap < 9'(4 * DEG_PER_SECTOR))
        begin
            sec_next = SEC_CYAN_BLU;
            rem_next = 6'(hue_wrap - 9'(3 * DEG_PER_SECTOR));
        end
        else if (hue_wrap < 9'(5 * DEG_PER_SECTOR))
        begin
            sec_next = SEC_BLU_MAG;
            rem_next = 6'(hue_wrap - 9'(4 * DEG_PER_SECTOR));
        end
        else
        begin
            sec_next = SEC_MAG_RED;
            rem_next = 6'(hue_wrap - 9'(5 * DEG_PER_SECTOR));
        end
    end

    // Stage 2: per-channel multiplicands over the common denominator.
    always_comb
    begin
        rem_inv        = DEG_C - rem_s1_reg;
        cr_q           = col_s1_reg * rem_s1_reg;
        cr_t           = col_s1_reg * rem_inv;
        m_next[LANE_V] = FULLM_C;
        m_next[LANE_P] = MW'((SIDE_C - MW'(col_s1_reg)) * DEG_M);
        m_next[LANE_Q] = FULLM_C - MW'(cr_q);
        m_next[LANE_T] = FULLM_C - MW'(cr_t);
    end

    // Stages 3..6 run the same divide datapath on every lane.
    always_comb
    begin
        for (int i = 0; i < NUM_LANE; i++)
        begin
            y_ext[i]  = (MW + 16)'(row_s2_reg) * (MW + 16)'(m_s2_reg[i]);
            // Times 255 as times 256 minus one.
            x_next[i] = XW'((y_ext[i] << 8) - y_ext[i]);
            prod[i]   = PW'(x_s3_reg[i]) * PW'(RECIP_C);
            ed[i]     = (DW + 8)'(est_s4_reg[i]) * (DW + 8)'(DEN_C);
            rem_x[i]  = x_s5_reg[i] - ed_s5_reg[i];
            q_next[i] = est_s5_reg[i] + 8'(rem_x[i] >= DEN_X);
        end
    end

    // Stage 7: route channels by sector.
    always_comb
    begin
        unique case (sec_s6_reg)
            SEC_RED_YEL:
            begin
                red_next   = q_s6_reg[LANE_V];
                green_next = q_s6_reg[LANE_T];
                blue_next  = q_s6_reg[LANE_P];
            end
            SEC_YEL_GRN:
            begin
                red_next   = q_s6_reg[LANE_Q];
                green_next = q_s6_reg[LANE_V];
                blue_next  = q_s6_reg[LANE_P];
            end
            SEC_GRN_CYAN:
            begin
                red_next   = q_s6_reg[LANE_P];
                green_next = q_s6_reg[LANE_V];
                blue_next  = q_s6_reg[LANE_T];
            end
            SEC_CYAN_BLU:
            begin
                red_next   = q_s6_reg[LANE_P];
                green_next = q_s6_reg[LANE_Q];
                blue_next  = q_s6_reg[LANE_V];
            end
            SEC_BLU_MAG:
            begin
                red_next   = q_s6_reg[LANE_T];
                green_next = q_s6_reg[LANE_P];
                blue_next  = q_s6_reg[LANE_V];
            end
            default:
            begin
                red_next   = q_s6_reg[LANE_V];
                green_next = q_s6_reg[LANE_P];
                blue_next  = q_s6_reg[LANE_Q];
            end
        endcase
    end

    // Payload registers advance every cycle; valid bits mark live items.
    always_ff @(posedge clk)
    begin
        col_s1_reg <= col_next;
        row_s1_reg <= row_next;
        rem_s1_reg <= rem_next;
        sec_s1_reg <= sec_next;
        row_s2_reg <= row_s1_reg;
        sec_s2_reg <= sec_s1_reg;
        sec_s3_reg <= sec_s2_reg;
        sec_s4_reg <= sec_s3_reg;
        sec_s5_reg <= sec_s4_reg;
        sec_s6_reg <= sec_s5_reg;
        for (int i = 0; i < NUM_LANE; i++)
        begin
            m_s2_reg[i]   <= m_next[i];
            x_s3_reg[i]   <= x_next[i];
            x_s4_reg[i]   <= x_s3_reg[i];
            est_s4_reg[i] <= prod[i][SH+7:SH];
            x_s5_reg[i]   <= x_s4_reg[i];
            ed_s5_reg[i]  <= XW'(ed[i]);
            est_s5_reg[i] <= est_s4_reg[i];
            q_s6_reg[i]   <= q_next[i];
        end
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = vld_reg[7];
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the HSV gradient pixel to RGB converter.
`timescale 1ns / 1ps

module testbench;
    import hsvg_pkg::*;

    localparam int SIDE        = SIDE_DEFAULT;
    localparam int PIPE_DEPTH  = 7;     // depth of the converter pipeline
    localparam int STALL_LIMIT = 1000;  // cycles with no handshake before giving up
    localparam int N_DIRECTED  = 22;
    localparam int N_SEGMENTS  = 30;
    localparam int SEG_ITEMS   = 52;    // 30 x 52 random items after the directed rows
    localparam int N_IDLE_MODE = 3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One directed row: hue to program, pixel to send, and a typed-in color
    // where it is obvious (known = 1); other rows go through the predictor.
    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] col;
        logic [7:0] row;
        logic       known;
        rgb_t       rgb;
    } pixel_case_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       start          = 1'b0;
    logic       busy;
    logic [7:0] column         = 8'd0;
    logic [7:0] row            = 8'd0;
    logic       hue_degrees_we = 1'b0;
    logic [8:0] hue_degrees    = 9'd0;
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    rgb_t       pending_rgb[$];     // colors still owed by the pipeline, oldest first
    logic [8:0] hue_setting = 9'd0; // our copy of the hue register
    int         fail_count   = 0;
    int         stall_cycles = 0;

    pixel_case_t directed_pixels [0:N_DIRECTED-1] = '{
        // black row, both extreme columns
        '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{9'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        // zero saturation at full value is grey 254 for any hue
        '{9'd0,   8'd0,   8'd255, 1'b1, '{8'd254, 8'd254, 8'd254}},
        // full saturation and value on the primary and secondary corners, and other pixels across the sectors
        '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd254, 8'd0,   8'd0  }},
        '{9'd0,   8'd128, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd0,   8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd59,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd59,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd254, 8'd254, 8'd0  }},
        '{9'd60,  8'd77,  8'd190, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd119, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd254, 8'd0  }},
        '{9'd179, 8'd200, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd180, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd239, 8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd254}},
        '{9'd300, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd359, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd359, 8'd100, 8'd50,  1'b0, '{8'd0,   8'd0,   8'd0  }},
        // hue past a full turn wraps: 360 is red again, 511 is hue 151
        '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd254, 8'd0,   8'd0  }},
        '{9'd511, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
        '{9'd511, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }}
    };

    // Sender idle percentage per random segment: a clean stretch first.
    int idle_modes [0:N_IDLE_MODE-1] = '{0, 45, 22};

    hsv_gradient_pixel_to_rgb #(
        .SIDE(SIDE)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .column         (column),
        .row            (row),
        .hue_degrees_we (hue_degrees_we),
        .hue_degrees    (hue_degrees),
        .done           (done),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Predict the color of pixel (col_in, row_in) for hue register value hue_in.
    // Every channel is an exact floor of a rational, so plain wide unsigned
    // integer math gives the bit-exact answer.
    function automatic rgb_t hsv_pixel_rgb(input logic [7:0] col_in,
                                           input logic [7:0] row_in,
                                           input logic [8:0] hue_in);
        longint unsigned side_w;
        longint unsigned sat_col;
        longint unsigned val_row;
        longint unsigned hue_w;
        longint unsigned frac;
        longint unsigned span;
        longint unsigned den_sq;
        longint unsigned den_frac;
        longint unsigned chan_v;
        longint unsigned chan_p;
        longint unsigned chan_q;
        longint unsigned chan_t;
        sector_t         sector;
        rgb_t            color;

        side_w   = longint'(SIDE);
        // coordinates past the square saturate to its last pixel
        sat_col  = (col_in > side_w - 1) ? side_w - 1 : longint'(col_in);
        val_row  = (row_in > side_w - 1) ? side_w - 1 : longint'(row_in);
        hue_w    = longint'(hue_in) % longint'(DEG_FULL_TURN);
        sector   = sector_t'(hue_w / longint'(DEG_PER_SECTOR));
        frac     = hue_w % longint'(DEG_PER_SECTOR);
        span     = longint'(DEG_PER_SECTOR) * side_w;
        den_sq   = side_w * side_w;
        den_frac = den_sq * longint'(DEG_PER_SECTOR);

        chan_v = val_row * longint'(FULL_SCALE) / side_w;
        chan_p = val_row * (side_w - sat_col) * longint'(FULL_SCALE) / den_sq;
        chan_q = val_row * (span - sat_col * frac) * longint'(FULL_SCALE) / den_frac;
        chan_t = val_row * (span - sat_col * (longint'(DEG_PER_SECTOR) - frac))
                 * longint'(FULL_SCALE) / den_frac;

        case (sector)
            SEC_RED_YEL:  color = '{chan_v[7:0], chan_t[7:0], chan_p[7:0]};
            SEC_YEL_GRN:  color = '{chan_q[7:0], chan_v[7:0], chan_p[7:0]};
            SEC_GRN_CYAN: color = '{chan_p[7:0], chan_v[7:0], chan_t[7:0]};
            SEC_CYAN_BLU: color = '{chan_p[7:0], chan_q[7:0], chan_v[7:0]};
            SEC_BLU_MAG:  color = '{chan_t[7:0], chan_p[7:0], chan_v[7:0]};
            default:      color = '{chan_v[7:0], chan_p[7:0], chan_q[7:0]};
        endcase
        return color;
    endfunction

    // Mostly uniform coordinates, with the edges of the square drawn often.
    function automatic logic [7:0] pick_coord();
        logic [7:0] coord;

        if ($urandom_range(7) == 0)
            coord = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        else
            coord = 8'($urandom_range(255));
        return coord;
    endfunction

    // Compare one channel and count a miss; only the first ten are printed.
    function automatic void check_channel(input string chan_name,
                                          input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $realtime, chan_name, want, got);
        end
    endfunction

    // Send one pixel item. Hold start low for a random number of cycles
    // first, then raise it and wait for the accepting edge. start stays high
    // on return so back-to-back items need no extra assignment.
    task automatic send_pixel(input logic [7:0] px_col,
                              input logic [7:0] px_row,
                              input logic       known,
                              input rgb_t       typed,
                              input int         idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        column <= px_col;
        row    <= px_row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // item taken at this edge: queue what it must produce
        pending_rgb.push_back(known ? typed : hsv_pixel_rgb(px_col, px_row, hue_setting));
    endtask

    // Drop start and let the pipeline drain until every owed color is out.
    task automatic drain_pipeline();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rgb.size() != 0);
    endtask

    // Write the hue register once the block is idle.
    task automatic program_hue(input logic [8:0] value);
        drain_pipeline();
        repeat (PIPE_DEPTH)
            @(posedge clk);
        hue_degrees_we <= 1'b1;
        hue_degrees    <= value;
        @(posedge clk);
        hue_degrees_we <= 1'b0;
        hue_setting = value;
    endtask

    // Result checker: every done strobe is one color, taken at the edge
    // that ends its cycle. Advance the stall counter when nothing moves.
    always @(posedge clk)
    begin
        rgb_t want;
        logic moved;

        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
                moved = 1'b1;
            if (done)
            begin
                moved = 1'b1;
                if (pending_rgb.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %0d %0d %0d",
                                 $realtime, red, green, blue);
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    check_channel("red",   want.red,   red);
                    check_channel("green", want.green, green);
                    check_channel("blue",  want.blue,  blue);
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog: end the run if handshakes stop for too long.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus: reset, directed rows, then random segments each with its own
    // hue and sender idle rate.
    initial
    begin
        logic [8:0] seg_hue;
        int         hue_corner [$];
        rgb_t       no_color;

        hue_corner = '{0, 511, 359, 360, 59, 60, 119, 120, 179, 180, 239, 240,
                       299, 300, 1, 256};
        no_color = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: program the hue for the first row, then only when a row asks for a new one
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (i == 0 || directed_pixels[i].hue != hue_setting)
                program_hue(directed_pixels[i].hue);
            send_pixel(directed_pixels[i].col, directed_pixels[i].row,
                       directed_pixels[i].known, directed_pixels[i].rgb, 0);
        end

        // random segments: corner hues first, then random register values
        for (int seg = 0; seg < N_SEGMENTS; seg++)
        begin
            if (seg < hue_corner.size())
                seg_hue = 9'(hue_corner[seg]);
            else
                seg_hue = 9'($urandom_range(511));
            program_hue(seg_hue);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_pixel(pick_coord(), pick_coord(), 1'b0, no_color,
                           idle_modes[seg % N_IDLE_MODE]);
        end

        // let everything owed arrive, then watch a while for stray strobes
        drain_pipeline();
        repeat (2 * PIPE_DEPTH)
            @(posedge clk);

        if (fail_count == 0 && pending_rgb.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
